[rtl/sgr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types, constants and helpers of the scaled glyph row generator.
// ----------------------------------------------------------------------------
package sgr_pkg;

  // Parameter defaults.
  localparam int unsigned MaxScaleDef   = 4;
  localparam int unsigned GlyphRowsDef  = 16;
  localparam int unsigned GlyphCountDef = 256;

  // Fixed field widths, sized for the largest parameter values.
  localparam int unsigned CharW      = 9;   // glyph index, up to 512 glyphs
  localparam int unsigned RowW       = 4;   // glyph row, up to 16 rows
  localparam int unsigned HeaderLen  = 4;   // PSF1 header bytes
  localparam int unsigned HeightByte = 3;   // header byte that holds the height
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned CfgW       = 32;
  localparam int unsigned CfgIdxW    = 2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgScale = 2'd0,
    CfgFg    = 2'd1,
    CfgBg    = 2'd2
  } sgr_cfg_idx_e;

  // Kind of work handed from the front to the back.
  typedef enum logic {
    KindWrite = 1'b0,
    KindDraw  = 1'b1
  } sgr_kind_e;

  // Back-end sequencer states.
  typedef enum logic {
    BkIdle = 1'b0,
    BkDraw = 1'b1
  } sgr_back_state_e;

  // One queue entry: a glyph store write or a draw command.
  typedef struct packed {
    sgr_kind_e        kind;
    logic [CharW-1:0] chr;
    logic [RowW-1:0]  row;
    logic [7:0]       data;
    logic [15:0]      x;
    logic [15:0]      y;
  } sgr_entry_t;

  // Expand one glyph row into a mask; bit k takes glyph bit 7 - k/s.
  function automatic logic [31:0] sgr_expand(logic [7:0] bits, logic [2:0] s);
    logic [31:0] m;
    m = '0;
    case (s)
      3'd2: begin
        for (int k = 0; k < 16; k++) m[k] = bits[7 - k / 2];
      end
      3'd3: begin
        for (int k = 0; k < 24; k++) m[k] = bits[7 - k / 3];
      end
      3'd4: begin
        for (int k = 0; k < 32; k++) m[k] = bits[7 - k / 4];
      end
      default: begin
        for (int k = 0; k < 8; k++) m[k] = bits[7 - k];
      end
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

[rtl/scaled_glyph_row_generator.sv]
`default_nettype none
// Draw: a command passes the queue, the row sequencer, the store read and the
// output stage; its beats, one per glyph row and scale step, follow on consecutive
// cycles and cannot be stalled. A draw holds the back until its last row is issued.
// Font byte: one per cycle while busy_o is low; glyph bytes are stored as popped.
// busy_o is high only while the 4-entry queue is full.
// Reset: scale 1, white on black, parser at file start with height 16, store unloaded.
// ----------------------------------------------------------------------------
// scaled_glyph_row_generator
// Character generator with a loadable PSF1 font store and scaled row output.
// ----------------------------------------------------------------------------
module scaled_glyph_row_generator
  import sgr_pkg::*;
#(
  parameter int unsigned MAX_SCALE   = MaxScaleDef,
  parameter int unsigned GLYPH_ROWS  = GlyphRowsDef,
  parameter int unsigned GLYPH_COUNT = GlyphCountDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic               mode_i,
  input  wire logic               file_start_i,
  input  wire logic [7:0]         font_byte_i,
  input  wire logic [7:0]         char_code_i,
  input  wire logic [15:0]        x_pos_i,
  input  wire logic [15:0]        y_pos_i,
  output logic                    row_valid_o,
  output logic [15:0]             row_x_o,
  output logic [15:0]             row_y_o,
  output logic [5:0]              pixel_count_o,
  output logic [31:0]             pixel_mask_o,
  output logic [31:0]             fg_out_o,
  output logic [31:0]             bg_out_o,
  output logic                    last_row_o
);

  sgr_entry_t push_entry, head_entry;
  logic       push, pop, q_empty, q_full;

  // Front: item acceptance and font stream parsing.
  sgr_front #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .mode_i       (mode_i),
    .file_start_i (file_start_i),
    .font_byte_i  (font_byte_i),
    .char_code_i  (char_code_i),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .q_full_i     (q_full),
    .busy_o       (busy_o),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // Work queue between the two halves.
  sgr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Back: glyph store and row sequencer.
  sgr_back #(
    .MAX_SCALE   (MAX_SCALE),
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .q_entry_i     (head_entry),
    .q_empty_i     (q_empty),
    .q_pop_o       (pop),
    .row_valid_o   (row_valid_o),
    .row_x_o       (row_x_o),
    .row_y_o       (row_y_o),
    .pixel_count_o (pixel_count_o),
    .pixel_mask_o  (pixel_mask_o),
    .fg_out_o      (fg_out_o),
    .bg_out_o      (bg_out_o),
    .last_row_o    (last_row_o)
  );

endmodule
`default_nettype wire

[rtl/sgr_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_queue
// Short FIFO of work entries between the front and the back.
// ----------------------------------------------------------------------------
module sgr_queue
  import sgr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire sgr_entry_t entry_i,
  input  wire logic       pop_i,
  output sgr_entry_t      entry_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  sgr_entry_t            slot_q [QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign entry_o = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  // The front never pushes into a full queue, the back never pops an empty one.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth)) else $error("queue count out of range");

endmodule
`default_nettype wire

[rtl/sgr_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_front
// Accepts items, parses the font file stream and queues store writes and
// draw commands.
// ----------------------------------------------------------------------------
module sgr_front
  import sgr_pkg::*;
#(
  parameter int unsigned GLYPH_ROWS  = GlyphRowsDef,
  parameter int unsigned GLYPH_COUNT = GlyphCountDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        mode_i,
  input  wire logic        file_start_i,
  input  wire logic [7:0]  font_byte_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [15:0] x_pos_i,
  input  wire logic [15:0] y_pos_i,
  input  wire logic        q_full_i,
  output logic             busy_o,
  output logic             push_o,
  output sgr_entry_t       entry_o
);

  localparam int unsigned LcW = $clog2(GLYPH_COUNT + 1);
  localparam int unsigned HcW = 3;

  logic [HcW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [7:0]     height_q, height_d;
  logic [LcW-1:0] load_char_q, load_char_d;
  logic [7:0]     load_row_q, load_row_d;

  logic           accept;
  logic [HcW-1:0] hc;
  logic [LcW-1:0] lc;
  logic [7:0]     lr;
  logic [8:0]     lr_next;
  logic           store;
  logic [9:0]     code_w;

  assign busy_o = q_full_i;
  assign accept = start_i && !busy_o;

  // Font stream parser and entry build.
  always_comb begin
    hc          = file_start_i ? '0 : hdr_cnt_q;
    lc          = file_start_i ? '0 : load_char_q;
    lr          = file_start_i ? '0 : load_row_q;
    lr_next     = {1'b0, lr} + 9'd1;
    hdr_cnt_d   = hdr_cnt_q;
    height_d    = height_q;
    load_char_d = load_char_q;
    load_row_d  = load_row_q;
    store       = 1'b0;

    if (accept && !mode_i) begin
      hdr_cnt_d   = hc;
      load_char_d = lc;
      load_row_d  = lr;
      if (32'(hc) < HeaderLen) begin
        if (32'(hc) == HeightByte) begin
          height_d = font_byte_i;
        end
        hdr_cnt_d = hc + 1'b1;
      end else if (height_q != 8'd0 && 32'(lc) < GLYPH_COUNT) begin
        store = (32'(lr) < GLYPH_ROWS);
        if (lr_next >= {1'b0, height_q}) begin
          load_row_d  = '0;
          load_char_d = lc + 1'b1;
        end else begin
          load_row_d = lr_next[7:0];
        end
      end
    end

    // Code minus glyph count if at or above it; modulo for counts >= 128.
    code_w = {2'b00, char_code_i};
    if (32'(code_w) >= GLYPH_COUNT) begin
      code_w = code_w - 10'(GLYPH_COUNT);
    end

    entry_o.x    = x_pos_i;
    entry_o.y    = y_pos_i;
    entry_o.data = font_byte_i;
    if (mode_i) begin
      entry_o.kind = KindDraw;
      entry_o.chr  = code_w[CharW-1:0];
      entry_o.row  = '0;
    end else begin
      entry_o.kind = KindWrite;
      entry_o.chr  = CharW'(lc);
      entry_o.row  = lr[RowW-1:0];
    end
    push_o = accept && (mode_i || store);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q   <= '0;
      height_q    <= 8'd16;
      load_char_q <= '0;
      load_row_q  <= '0;
    end else begin
      hdr_cnt_q   <= hdr_cnt_d;
      height_q    <= height_d;
      load_char_q <= load_char_d;
      load_row_q  <= load_row_d;
    end
  end

  // Parser counters stay in range.
  a_hdr_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(hdr_cnt_q) <= HeaderLen) else $error("header count past header");
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(load_char_q) <= GLYPH_COUNT) else $error("load glyph past store");
  a_store_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !mode_i) |-> (32'(hc) == HeaderLen && height_q != 8'd0))
    else $error("store write outside glyph data");

endmodule
`default_nettype wire

[rtl/sgr_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sgr_back
// Glyph store, configuration registers and the row sequencer that turns a
// draw command into scaled mask rows.
// ----------------------------------------------------------------------------
module sgr_back
  import sgr_pkg::*;
#(
  parameter int unsigned MAX_SCALE   = MaxScaleDef,
  parameter int unsigned GLYPH_ROWS  = GlyphRowsDef,
  parameter int unsigned GLYPH_COUNT = GlyphCountDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire sgr_entry_t         q_entry_i,
  input  wire logic               q_empty_i,
  output logic                    q_pop_o,
  output logic                    row_valid_o,
  output logic [15:0]             row_x_o,
  output logic [15:0]             row_y_o,
  output logic [5:0]              pixel_count_o,
  output logic [31:0]             pixel_mask_o,
  output logic [31:0]             fg_out_o,
  output logic [31:0]             bg_out_o,
  output logic                    last_row_o
);

  localparam int unsigned Depth = GLYPH_COUNT * GLYPH_ROWS;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned GrW   = $clog2(GLYPH_ROWS);
  localparam int unsigned SubW  = $clog2(MAX_SCALE + 1);

  // Configuration registers.
  logic [2:0]  scale_q;
  logic [31:0] fg_q, bg_q;
  logic [2:0]  scale_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 3'd1;
      fg_q    <= '1;
      bg_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgScale: scale_q <= cfg_data_i[2:0];
        CfgFg:    fg_q    <= cfg_data_i;
        CfgBg:    bg_q    <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Scale clamped to 1..MAX_SCALE.
  always_comb begin
    if (scale_q == 3'd0) begin
      scale_eff = 3'd1;
    end else if (32'(scale_q) > MAX_SCALE) begin
      scale_eff = 3'(MAX_SCALE);
    end else begin
      scale_eff = scale_q;
    end
  end

  // Sequencer registers.
  sgr_back_state_e  state_q, state_d;
  logic [CharW-1:0] code_q, code_d;
  logic [15:0]      x_q, x_d;
  logic [15:0]      ry_q, ry_d;
  logic [2:0]       s_q, s_d;
  logic [GrW-1:0]   gr_q, gr_d;
  logic [SubW-1:0]  sub_q, sub_d;

  logic             mem_we, mem_re, issue_last;
  logic [AddrW-1:0] mem_waddr, mem_raddr;

  // Next state: pop when idle, write stores on the pop, draw one row a cycle.
  always_comb begin
    state_d    = state_q;
    code_d     = code_q;
    x_d        = x_q;
    ry_d       = ry_q;
    s_d        = s_q;
    gr_d       = gr_q;
    sub_d      = sub_q;
    q_pop_o    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    issue_last = 1'b0;
    mem_waddr  = AddrW'(32'(q_entry_i.chr) * GLYPH_ROWS + 32'(q_entry_i.row));
    mem_raddr  = AddrW'(32'(code_q) * GLYPH_ROWS + 32'(gr_q));

    case (state_q)
      BkIdle: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_entry_i.kind == KindWrite) begin
            mem_we = 1'b1;
          end else begin
            code_d  = q_entry_i.chr;
            x_d     = q_entry_i.x;
            ry_d    = q_entry_i.y;
            s_d     = scale_eff;
            gr_d    = '0;
            sub_d   = '0;
            state_d = BkDraw;
          end
        end
      end
      BkDraw: begin
        mem_re = 1'b1;
        ry_d   = ry_q + 16'd1;
        if (3'(sub_q) == s_q - 3'd1) begin
          sub_d = '0;
          gr_d  = gr_q + 1'b1;
          if (32'(gr_q) == GLYPH_ROWS - 1) begin
            issue_last = 1'b1;
            state_d    = BkIdle;
          end
        end else begin
          sub_d = sub_q + 1'b1;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    x_q    <= x_d;
    ry_q   <= ry_d;
    s_q    <= s_d;
    gr_q   <= gr_d;
    sub_q  <= sub_d;
  end

  // Glyph store with registered read.
  logic [7:0] store_mem [Depth];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= q_entry_i.data;
    end
    if (mem_re) begin
      rd_q <= store_mem[mem_raddr];
    end
  end

  // Row attributes travelling alongside the store read.
  logic        v1_q;
  logic        last1_q;
  logic [15:0] y1_q, x1_q;
  logic [2:0]  s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= mem_re;
    end
  end

  always_ff @(posedge clk_i) begin
    last1_q <= issue_last;
    y1_q    <= ry_q;
    x1_q    <= x_q;
    s1_q    <= s_q;
  end

  // Output stage: expand the glyph row into the scaled mask.
  logic        v2_q;
  logic        last2_q;
  logic [15:0] y2_q, x2_q;
  logic [5:0]  cnt2_q;
  logic [31:0] mask2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q    <= 1'b0;
      last2_q <= 1'b0;
    end else begin
      v2_q    <= v1_q;
      last2_q <= v1_q && last1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    y2_q    <= y1_q;
    x2_q    <= x1_q;
    cnt2_q  <= {s1_q, 3'b000};
    mask2_q <= sgr_expand(rd_q, s1_q);
  end

  assign row_valid_o   = v2_q;
  assign last_row_o    = last2_q;
  assign row_x_o       = x2_q;
  assign row_y_o       = y2_q;
  assign pixel_count_o = cnt2_q;
  assign pixel_mask_o  = mask2_q;
  assign fg_out_o      = fg_q;
  assign bg_out_o      = bg_q;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == BkIdle)) else $error("pop during a draw");
  a_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_row_o |-> row_valid_o) else $error("last row without a beat");
  a_count_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_valid_o |-> (pixel_count_o[2:0] == 3'd0 && pixel_count_o != 6'd0))
    else $error("bad pixel count");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_last |=> (state_q == BkIdle)) else $error("draw ran past its last row");

endmodule
`default_nettype wire
